@@ hw/rtl/frg_pkg.sv @@
// Shared types and constants for the message fragmenter.
package frg_pkg;

    // Sizes of the descriptor fields and of the bandwidth register
    localparam int LEN_W = 24;
    localparam int ID_W  = 32;
    localparam int GAP_W = 32;
    localparam int BW_W  = 31;

    // Chunking: the payload size is a power of two, so the chunk split is a shift
    localparam int PAYLOAD_BYTES = 1024;
    localparam int PAY_SH        = $clog2(PAYLOAD_BYTES);
    localparam logic [LEN_W-1:0] PAY_MASK = LEN_W'(PAYLOAD_BYTES - 1);
    localparam logic [LEN_W-1:0] PAY_LEN  = LEN_W'(PAYLOAD_BYTES);

    localparam int BUFFER_BYTES = 1024;
    localparam int MAX_PACKETS  = 63;
    localparam int CNT_W        = $clog2(MAX_PACKETS + 1);

    // Pacing gap divider: dividend is the buffer size in byte-microseconds
    localparam longint unsigned GAP_DIVIDEND = 64'(BUFFER_BYTES) * 64'd1000000;
    localparam int GAP_QW    = $clog2(GAP_DIVIDEND + 1);
    localparam int GAP_CNT_W = $clog2(GAP_QW + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Generator seeds
    localparam logic [ID_W-1:0] RNG_SEED_A = 32'd123456789;
    localparam logic [ID_W-1:0] RNG_SEED_B = 32'd362436069;
    localparam logic [ID_W-1:0] RNG_SEED_C = 32'd521288629;

    localparam logic [ID_W-1:0] COMBINED_ID = '1;

    // Descriptor kinds; also used to classify commands
    typedef enum logic [1:0] {
        KIND_COMBINED = 2'd0,
        KIND_START    = 2'd1,
        KIND_CONTENT  = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    // One classified message on its way to the back end
    typedef struct packed {
        kind_t              kind;
        logic [LEN_W-1:0]   len;
        logic [CNT_W-1:0]   count;
    } cmd_t;

endpackage

@@ hw/rtl/frg_gap_div.sv @@
// Restoring divider that turns the bandwidth register into a pacing gap.
module frg_gap_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [frg_pkg::BW_W-1:0]    cfg_wdata,
    output logic [frg_pkg::GAP_W-1:0]   gap,
    output logic                        busy
);
    import frg_pkg::*;

    logic [GAP_QW-1:0]    quo_reg, quo_next;
    logic [BW_W:0]        rem_reg, rem_next;
    logic [BW_W-1:0]      div_reg, div_next;
    logic [GAP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [GAP_W-1:0]     gap_reg, gap_next;

    logic [BW_W:0]        rem_sh;
    logic                 fits;
    logic [GAP_QW-1:0]    quo_step;
    logic [63:0]          quo_wide;

    // One quotient bit per cycle while busy
    always_comb
    begin
        rem_sh   = {rem_reg[BW_W-1:0], quo_reg[GAP_QW-1]};
        fits     = rem_sh >= {1'b0, div_reg};
        quo_step = {quo_reg[GAP_QW-2:0], fits};
        quo_wide = 64'(quo_step);
    end

    // Load on a write; zero clears gap, else iterate, saturate into gap
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        gap_next  = gap_reg;
        if (cfg_we) begin
            div_next = cfg_wdata;
            quo_next = GAP_QW'(GAP_DIVIDEND);
            rem_next = '0;
            cnt_next = GAP_CNT_W'(GAP_QW);
            if (cfg_wdata == '0) begin
                busy_next = 1'b0;
                gap_next  = '0;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            quo_next = quo_step;
            rem_next = fits ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == GAP_CNT_W'(1)) begin
                busy_next = 1'b0;
                gap_next  = (|quo_wide[63:32]) ? '1 : quo_wide[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            gap_reg  <= '0;
        end else begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            gap_reg  <= gap_next;
        end
    end

    assign gap  = gap_reg;
    assign busy = busy_reg;

endmodule

@@ hw/rtl/frg_front.sv @@
// Front end: accepts message lengths and classifies them into commands.
module frg_front (
    input  logic                        push,
    input  logic [frg_pkg::LEN_W-1:0]   message_length,
    input  logic                        q_full,
    input  logic                        div_busy,
    output logic                        full,
    output logic                        q_wr,
    output frg_pkg::cmd_t               q_wdata
);
    import frg_pkg::*;

    logic [LEN_W:0] chunks;

    // Count chunks, rounding a partial chunk up
    always_comb
    begin
        chunks = (LEN_W+1)'(message_length >> PAY_SH)
               + (LEN_W+1)'(|(message_length & PAY_MASK));
    end

    // Classify: one chunk is combined, too many is an error, else split
    always_comb
    begin
        q_wdata.len   = message_length;
        q_wdata.count = CNT_W'(chunks);
        if (chunks == (LEN_W+1)'(1)) begin
            q_wdata.kind = KIND_COMBINED;
        end else if (chunks > (LEN_W+1)'(MAX_PACKETS)) begin
            q_wdata.kind = KIND_ERROR;
        end else begin
            q_wdata.kind = KIND_START;
        end
    end

    // Hold off while the queue is full or the gap is being worked out
    assign full = q_full | div_busy;
    assign q_wr = push & ~full;

endmodule

@@ hw/rtl/frg_queue.sv @@
// Short command queue between the front and back ends.
module frg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  frg_pkg::cmd_t   wdata,
    input  logic            rd,
    output frg_pkg::cmd_t   rdata,
    output logic            full,
    output logic            empty
);
    import frg_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next;
    logic [QPTR_W-1:0] rp_reg, rp_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    // Advance pointers and fill count
    always_comb
    begin
        wp_next   = wr ? (wp_reg + 1'b1) : wp_reg;
        rp_next   = rd ? (rp_reg + 1'b1) : rp_reg;
        fill_next = fill_reg + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    // Store words
    always_ff @(posedge clk)
    begin
        if (wr) begin
            mem[wp_reg] <= wdata;
        end
    end

    assign rdata = mem[rp_reg];
    assign full  = fill_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty = fill_reg == '0;

endmodule

@@ hw/rtl/frg_back.sv @@
// Back end: sequences descriptors per command and owns the id generator.
module frg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  frg_pkg::cmd_t               q_rdata,
    input  logic                        q_empty,
    output logic                        q_rd,
    input  logic [frg_pkg::GAP_W-1:0]   gap,
    input  logic                        pop,
    output logic                        empty,
    output logic [1:0]                  packet_kind,
    output logic [frg_pkg::ID_W-1:0]    message_id,
    output logic [frg_pkg::LEN_W-1:0]   packet_number,
    output logic [frg_pkg::LEN_W-1:0]   packet_length,
    output logic [frg_pkg::LEN_W-1:0]   buffer_offset,
    output logic [frg_pkg::GAP_W-1:0]   gap_us,
    output logic                        last
);
    import frg_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_BODY
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [ID_W-1:0]   rng_a_reg, rng_a_next;
    logic [ID_W-1:0]   rng_b_reg, rng_b_next;
    logic [ID_W-1:0]   rng_c_reg, rng_c_next;

    logic              ov_reg, ov_next;
    kind_t             kind_reg, kind_next;
    logic [ID_W-1:0]   oid_reg, oid_next;
    logic [LEN_W-1:0]  num_reg, num_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic [LEN_W-1:0]  off_reg, off_next;
    logic [GAP_W-1:0]  gap_reg, gap_next;
    logic              last_reg, last_next;

    logic              slot_free;
    logic [ID_W-1:0]   mix;
    logic [ID_W-1:0]   fresh_id;
    logic              final_chunk;
    logic [LEN_W-1:0]  tail;

    // Next generator word
    always_comb
    begin
        mix      = rng_a_reg ^ (rng_a_reg << 16);
        mix      = mix ^ (mix >> 5);
        mix      = mix ^ (mix << 1);
        fresh_id = mix ^ rng_b_reg ^ rng_c_reg;
    end

    // Length of the closing chunk
    always_comb
    begin
        tail        = ((len_reg & PAY_MASK) == '0) ? PAY_LEN : (len_reg & PAY_MASK);
        final_chunk = CNT_W'(k_reg + 1'b1) == cnt_reg;
    end

    assign slot_free = ~ov_reg | pop;
    assign q_rd      = (state_reg == ST_IDLE) & ~q_empty & slot_free;

    // Sequence descriptors into the output register
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        id_next    = id_reg;
        rng_a_next = rng_a_reg;
        rng_b_next = rng_b_reg;
        rng_c_next = rng_c_reg;
        ov_next    = ov_reg & ~pop;
        kind_next  = kind_reg;
        oid_next   = oid_reg;
        num_next   = num_reg;
        olen_next  = olen_reg;
        off_next   = off_reg;
        gap_next   = gap_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_rd) begin
                    ov_next  = 1'b1;
                    off_next = '0;
                    gap_next = '0;
                    case (q_rdata.kind)
                        KIND_COMBINED:
                        begin
                            kind_next = KIND_COMBINED;
                            oid_next  = COMBINED_ID;
                            num_next  = LEN_W'(1);
                            olen_next = q_rdata.len;
                            last_next = 1'b1;
                        end
                        KIND_START:
                        begin
                            rng_a_next = rng_b_reg;
                            rng_b_next = rng_c_reg;
                            rng_c_next = fresh_id;
                            kind_next  = KIND_START;
                            oid_next   = fresh_id;
                            num_next   = LEN_W'(q_rdata.count);
                            olen_next  = q_rdata.len;
                            last_next  = q_rdata.count == '0;
                            id_next    = fresh_id;
                            len_next   = q_rdata.len;
                            cnt_next   = q_rdata.count;
                            k_next     = '0;
                            if (q_rdata.count != '0) begin
                                state_next = ST_BODY;
                            end
                        end
                        default:
                        begin
                            kind_next = KIND_ERROR;
                            oid_next  = '0;
                            num_next  = '0;
                            olen_next = '0;
                            last_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_BODY:
            begin
                if (slot_free) begin
                    ov_next   = 1'b1;
                    kind_next = KIND_CONTENT;
                    oid_next  = id_reg;
                    num_next  = LEN_W'(k_reg);
                    olen_next = final_chunk ? tail : PAY_LEN;
                    off_next  = LEN_W'(k_reg) << PAY_SH;
                    gap_next  = gap;
                    last_next = final_chunk;
                    k_next    = k_reg + 1'b1;
                    if (final_chunk) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            id_reg    <= '0;
            rng_a_reg <= RNG_SEED_A;
            rng_b_reg <= RNG_SEED_B;
            rng_c_reg <= RNG_SEED_C;
            ov_reg    <= 1'b0;
            kind_reg  <= KIND_COMBINED;
            oid_reg   <= '0;
            num_reg   <= '0;
            olen_reg  <= '0;
            off_reg   <= '0;
            gap_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            rng_a_reg <= rng_a_next;
            rng_b_reg <= rng_b_next;
            rng_c_reg <= rng_c_next;
            ov_reg    <= ov_next;
            kind_reg  <= kind_next;
            oid_reg   <= oid_next;
            num_reg   <= num_next;
            olen_reg  <= olen_next;
            off_reg   <= off_next;
            gap_reg   <= gap_next;
            last_reg  <= last_next;
        end
    end

    assign empty         = ~ov_reg;
    assign packet_kind   = kind_reg;
    assign message_id    = oid_reg;
    assign packet_number = num_reg;
    assign packet_length = olen_reg;
    assign buffer_offset = off_reg;
    assign gap_us        = gap_reg;
    assign last          = last_reg;

endmodule

@@ hw/rtl/message_fragmenter_with_random_id.sv @@
// A message's first descriptor reaches the result ports through the command queue and the output
// register. The back end issues one descriptor per cycle while the receiver pops; a message of n
// chunks gives n+1 descriptors and a combined or error message 1; the command queue holds 4 messages.
// A nonzero bandwidth write holds full high while the pacing divider runs (one bit/cycle).
// Reset clears the queue and output, sets bandwidth and gap to zero and reseeds the id generator.
module message_fragmenter_with_random_id (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [frg_pkg::BW_W-1:0]    cfg_wdata,
    input  logic                        push,
    output logic                        full,
    input  logic [frg_pkg::LEN_W-1:0]   message_length,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  packet_kind,
    output logic [frg_pkg::ID_W-1:0]    message_id,
    output logic [frg_pkg::LEN_W-1:0]   packet_number,
    output logic [frg_pkg::LEN_W-1:0]   packet_length,
    output logic [frg_pkg::LEN_W-1:0]   buffer_offset,
    output logic [frg_pkg::GAP_W-1:0]   gap_us,
    output logic                        last
);
    import frg_pkg::*;

    logic             div_busy;
    logic [GAP_W-1:0] gap;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;
    cmd_t             q_wdata;
    cmd_t             q_rdata;

    // Work out the pacing gap when bandwidth is written
    frg_gap_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .gap       (gap),
        .busy      (div_busy)
    );

    // Classify incoming lengths
    frg_front u_front (
        .push           (push),
        .message_length (message_length),
        .q_full         (q_full),
        .div_busy       (div_busy),
        .full           (full),
        .q_wr           (q_wr),
        .q_wdata        (q_wdata)
    );

    // Buffer commands
    frg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // Issue descriptors
    frg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_rdata       (q_rdata),
        .q_empty       (q_empty),
        .q_rd          (q_rd),
        .gap           (gap),
        .pop           (pop),
        .empty         (empty),
        .packet_kind   (packet_kind),
        .message_id    (message_id),
        .packet_number (packet_number),
        .packet_length (packet_length),
        .buffer_offset (buffer_offset),
        .gap_us        (gap_us),
        .last          (last)
    );

endmodule

@@ hw/rtl/frg_checker.sv @@
// Port-level checks for the message fragmenter, bound to the top level.
module frg_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [1:0]                  packet_kind,
    input  logic [frg_pkg::ID_W-1:0]    message_id,
    input  logic [frg_pkg::LEN_W-1:0]   packet_number,
    input  logic [frg_pkg::LEN_W-1:0]   buffer_offset,
    input  logic [frg_pkg::GAP_W-1:0]   gap_us,
    input  logic                        last
);
    import frg_pkg::*;

    // A waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(message_id) && $stable(packet_number)))
        else $error("waiting descriptor changed before pop");

    // Content words of one message follow back to back with rising index and same id
    a_body: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && packet_kind == KIND_CONTENT && !last)
        |=> (!empty && packet_kind == KIND_CONTENT
             && packet_number == $past(packet_number) + 1'b1
             && message_id == $past(message_id)))
        else $error("content sequence broken");

    // A start header with chunks to follow is followed by chunk zero of the same id
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && packet_kind == KIND_START && !last)
        |=> (!empty && packet_kind == KIND_CONTENT && packet_number == '0
             && message_id == $past(message_id) && buffer_offset == '0))
        else $error("start header not followed by first chunk");

    // Combined and error words close their message and carry fixed fields
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (packet_kind == KIND_COMBINED || packet_kind == KIND_ERROR))
        |-> (last && buffer_offset == '0 && gap_us == '0))
        else $error("single-word descriptor malformed");

endmodule

bind message_fragmenter_with_random_id frg_checker u_frg_checker (.*);

@@ tb/fragment_checker.sv @@
// Watches the fragmenter's channels, predicts every packet descriptor and compares.
`timescale 1ns / 100ps

module fragment_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [frg_pkg::BW_W-1:0]    cfg_wdata,
    input  logic                        push,
    input  logic                        full,
    input  logic [frg_pkg::LEN_W-1:0]   message_length,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [1:0]                  packet_kind,
    input  logic [frg_pkg::ID_W-1:0]    message_id,
    input  logic [frg_pkg::LEN_W-1:0]   packet_number,
    input  logic [frg_pkg::LEN_W-1:0]   packet_length,
    input  logic [frg_pkg::LEN_W-1:0]   buffer_offset,
    input  logic [frg_pkg::GAP_W-1:0]   gap_us,
    input  logic                        last,
    output int                          mismatch_count,
    output int                          words_due,
    output int                          words_checked
);
    import frg_pkg::*;

    typedef struct {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   number;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   offset;
        logic [GAP_W-1:0]   gap;
        logic               last;
    } descriptor_t;

    descriptor_t        descriptors_due [$];
    logic [BW_W-1:0]    bandwidth_copy;
    logic [ID_W-1:0]    gen_x, gen_y, gen_z;

    // Advance the 32-bit xorshift96 generator and return the fresh id
    function automatic logic [ID_W-1:0] draw_message_id();
        logic [ID_W-1:0] t;
        t = gen_x;
        t = t ^ (t << 16);
        t = t ^ (t >> 5);
        t = t ^ (t << 1);
        gen_x = gen_y;
        gen_y = gen_z;
        gen_z = t ^ gen_x ^ gen_y;
        return gen_z;
    endfunction

    function automatic descriptor_t make_word(kind_t kind, logic [ID_W-1:0] id,
                                              int number, int length, int offset,
                                              logic [GAP_W-1:0] gap, logic is_last);
        descriptor_t d;
        d.kind   = kind;
        d.id     = id;
        d.number = LEN_W'(number);
        d.length = LEN_W'(length);
        d.offset = LEN_W'(offset);
        d.gap    = gap;
        d.last   = is_last;
        return d;
    endfunction

    // Queue up every descriptor that one message length gives
    task automatic predict_descriptors(input logic [LEN_W-1:0] len);
        int                 chunks;
        int                 remaining;
        int                 piece;
        longint unsigned    quotient;
        logic [GAP_W-1:0]   pacing;
        logic [ID_W-1:0]    id;
        chunks = int'(len) / PAYLOAD_BYTES;
        if ((int'(len) % PAYLOAD_BYTES) != 0)
            chunks++;
        if (chunks == 1)
        begin
            descriptors_due.push_back(make_word(KIND_COMBINED, COMBINED_ID, 1, int'(len),
                                                0, '0, 1'b1));
        end
        else if (chunks > MAX_PACKETS)
        begin
            descriptors_due.push_back(make_word(KIND_ERROR, '0, 0, 0, 0, '0, 1'b1));
        end
        else
        begin
            pacing = '0;
            if (bandwidth_copy != '0)
            begin
                quotient = (64'(BUFFER_BYTES) * 64'd1000000) / 64'(bandwidth_copy);
                pacing = (quotient > 64'hFFFF_FFFF) ? '1 : GAP_W'(quotient);
            end
            id = draw_message_id();
            descriptors_due.push_back(make_word(KIND_START, id, chunks, int'(len), 0, '0,
                                                chunks == 0));
            remaining = int'(len);
            for (int k = 0; k < chunks; k++)
            begin
                piece = (remaining > PAYLOAD_BYTES) ? PAYLOAD_BYTES : remaining;
                remaining -= piece;
                descriptors_due.push_back(make_word(KIND_CONTENT, id, k, piece,
                                                    k * PAYLOAD_BYTES, pacing,
                                                    k + 1 == chunks));
            end
        end
    endtask

    // Track configuration, predict on accepted messages, compare on accepted words
    always @(posedge clk or negedge rst_n)
    begin
        descriptor_t want;
        if (!rst_n)
        begin
            descriptors_due.delete();
            bandwidth_copy = '0;
            gen_x          = RNG_SEED_A;
            gen_y          = RNG_SEED_B;
            gen_z          = RNG_SEED_C;
            mismatch_count = 0;
            words_checked  = 0;
            words_due      = 0;
        end
        else
        begin
            if (cfg_we)
                bandwidth_copy = cfg_wdata;
            if (push && !full)
                predict_descriptors(message_length);
            if (pop && !empty)
            begin
                words_checked++;
                if (descriptors_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected word: kind %0d id %h num %0d len %0d",
                                 $realtime, packet_kind, message_id, packet_number,
                                 packet_length);
                end
                else
                begin
                    want = descriptors_due.pop_front();
                    if (packet_kind !== want.kind || message_id !== want.id
                        || packet_number !== want.number || packet_length !== want.length
                        || buffer_offset !== want.offset || gap_us !== want.gap
                        || last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("[%0t] word mismatch, expected: kind %0d id %h num %0d len %0d off %0d gap %0d last %0d",
                                     $realtime, want.kind, want.id, want.number, want.length,
                                     want.offset, want.gap, want.last);
                            $display("    actual: kind %0d id %h num %0d len %0d off %0d gap %0d last %0d",
                                     packet_kind, message_id, packet_number, packet_length,
                                     buffer_offset, gap_us, last);
                        end
                    end
                end
            end
            words_due = descriptors_due.size();
        end
    end

endmodule

@@ tb/message_fragmenter_with_random_id_tb.sv @@
// Stimulus, idling patterns and verdict for the message fragmenter testbench.
`timescale 1ns / 100ps

module message_fragmenter_with_random_id_tb;
    import frg_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [BW_W-1:0]        cfg_wdata = '0;
    logic                   push = 1'b0;
    logic [LEN_W-1:0]       message_length = '0;
    logic                   pop = 1'b0;
    logic                   full;
    logic                   empty;
    logic [1:0]             packet_kind;
    logic [ID_W-1:0]        message_id;
    logic [LEN_W-1:0]       packet_number;
    logic [LEN_W-1:0]       packet_length;
    logic [LEN_W-1:0]       buffer_offset;
    logic [GAP_W-1:0]       gap_us;
    logic                   last;

    int                     mismatch_count;
    int                     words_due;
    int                     words_checked;

    int                     idle_pct = 0;
    int                     stall_pct = 0;
    int                     holds_asked = 0;
    int                     holds_served = 0;
    int                     hold_left = 0;
    int                     quiet_cycles = 0;
    int                     messages_sent = 0;
    int                     settings_written = 0;

    // Lengths around the chunk boundaries, the field extremes and the error threshold
    logic [LEN_W-1:0]       corner_lengths [16] = '{
        24'd0, 24'd1, 24'd1023, 24'd1024, 24'd1025, 24'd2048, 24'd2049, 24'd3000,
        24'd5121, 24'd64511, 24'd64512, 24'd64513, 24'hFFFFFF, 24'h800000,
        24'hAAAAAA, 24'h555555
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    message_fragmenter_with_random_id DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .message_length (message_length),
        .empty          (empty),
        .pop            (pop),
        .packet_kind    (packet_kind),
        .message_id     (message_id),
        .packet_number  (packet_number),
        .packet_length  (packet_length),
        .buffer_offset  (buffer_offset),
        .gap_us         (gap_us),
        .last           (last)
    );

    fragment_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .message_length (message_length),
        .empty          (empty),
        .pop            (pop),
        .packet_kind    (packet_kind),
        .message_id     (message_id),
        .packet_number  (packet_number),
        .packet_length  (packet_length),
        .buffer_offset  (buffer_offset),
        .gap_us         (gap_us),
        .last           (last),
        .mismatch_count (mismatch_count),
        .words_due      (words_due),
        .words_checked  (words_checked)
    );

    // Receiver: stall at random, or hold off for a long stretch when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no word moved for %0d cycles", $realtime, QUIET_LIMIT);
                $display("message_fragmenter_with_random_id test failed");
                $finish;
            end
        end
    end

    // Offer one message length, idling first at random; returns on the accepting edge
    task automatic send_message(input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        message_length <= len;
        forever
        begin
            @(negedge clk);
            if (!full)
                break;
        end
        @(posedge clk);
        messages_sent++;
    endtask

    task automatic wait_drained();
        forever
        begin
            @(negedge clk);
            if (words_due == 0)
                break;
        end
    endtask

    // Write bandwidth only once every descriptor is out and the block has settled
    task automatic write_bandwidth(input logic [BW_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    // Mostly short multi-chunk messages, with empty, combined, long and oversized ones mixed in
    function automatic logic [LEN_W-1:0] pick_length();
        int roll;
        int chunks;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return LEN_W'($urandom_range(1, PAYLOAD_BYTES));
        if (roll < 25)
            return LEN_W'($urandom_range(MAX_PACKETS * PAYLOAD_BYTES + 1, 24'hFFFFFF));
        if (roll < 30)
            chunks = $urandom_range(9, MAX_PACKETS);
        else
            chunks = $urandom_range(2, 8);
        return LEN_W'((chunks - 1) * PAYLOAD_BYTES + $urandom_range(1, PAYLOAD_BYTES));
    endfunction

    task automatic run_phase(input int sender_idle, input int receiver_stall,
                             input int count);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        repeat (count)
            send_message(pick_length());
        push <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner lengths with pacing off from reset
        foreach (corner_lengths[i])
            send_message(corner_lengths[i]);
        push <= 1'b0;

        // Slowest pacing, then no idling
        write_bandwidth(31'd1);
        send_message(24'd2049);
        run_phase(0, 0, 35);

        // Fastest pacing, sender idling
        write_bandwidth(31'h7FFFFFFF);
        run_phase(47, 0, 35);

        // Random pacing, receiver stalling
        write_bandwidth(31'($urandom()));
        run_phase(0, 47, 35);

        // Pacing off again, both sides idling
        write_bandwidth(31'd0);
        run_phase(21, 21, 35);

        // Receiver holds off while the sender keeps offering, so the block fills up
        write_bandwidth(31'd1024000000);
        holds_asked++;
        idle_pct = 0;
        stall_pct = 0;
        repeat (15)
            send_message(LEN_W'(3 * PAYLOAD_BYTES + $urandom_range(1, PAYLOAD_BYTES)));
        push <= 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d messages and %0d checked descriptors over %0d bandwidth writes,",
                 messages_sent, words_checked, settings_written);
        $display("with four idling patterns and one long receiver hold-off.");
        if (mismatch_count == 0 && words_due == 0)
            $display("message_fragmenter_with_random_id test passed");
        else
            $display("message_fragmenter_with_random_id test failed");
        $finish;
    end

endmodule
